/* rtl/ugl_pkg.sv */
// Shared types and constants for the Unicode to GBK lookup block.
`timescale 1ns / 1ps

package ugl_pkg;

  // Width of a code point and of a GBK code
  localparam int CODE_W = 16;

  // Item modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // GBK code returned on a miss
  localparam logic [CODE_W-1:0] MISS_CODE = 16'h0000;

  // One table entry: code point in the upper half, GBK code in the lower half
  typedef struct packed {
    logic [CODE_W-1:0] unicode;
    logic [CODE_W-1:0] gbk;
  } entry_t;

  // Search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE
  } state_t;

endpackage

/* rtl/ugl_table.sv */
// Conversion table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ugl_table import ugl_pkg::*; #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ugl_search.sv */
// Request decode and binary search sequencer over the table memory.
`timescale 1ns / 1ps

module ugl_search import ugl_pkg::*; #(
  parameter int TABLE_DEPTH = 32768,
  parameter int AW          = 15,
  parameter int CW          = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              mode,
  input  logic [14:0]       entry_index,
  input  logic [CODE_W-1:0] entry_unicode,
  input  logic [CODE_W-1:0] entry_gbk,
  input  logic [CODE_W-1:0] search_key,
  input  logic [CODE_W-1:0] entries_used,
  output logic              busy,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output entry_t            mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  entry_t            mem_rdata,
  output logic              result_valid,
  output logic [CODE_W-1:0] gbk_code,
  output logic              found
);

  localparam logic [CODE_W:0] DEPTH_X = (CODE_W + 1)'(TABLE_DEPTH);

  state_t state, state_next;

  logic [CODE_W-1:0] key;
  logic [CW-1:0]     left;   // lowest candidate
  logic [CW-1:0]     rend;   // one past highest candidate
  logic [AW-1:0]     mid;

  logic          lookup_req;
  logic          write_req;
  logic          window_open;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_calc;
  logic [CW-1:0] n_sat;
  logic          hit;
  logic          key_below;
  logic          emit;
  logic          emit_found;
  logic [CODE_W-1:0] emit_code;

  // Request decode
  assign lookup_req = start && (state == ST_IDLE) && (mode == MODE_LOOKUP);
  assign write_req  = start && (state == ST_IDLE) && (mode == MODE_WRITE)
                      && ({2'b00, entry_index} < DEPTH_X);

  // Window size, saturated to the table depth
  assign n_sat = ({1'b0, entries_used} > DEPTH_X) ? CW'(TABLE_DEPTH) : CW'(entries_used);

  // Midpoint of the inclusive window, rounded down
  assign window_open = left < rend;
  assign mid_sum     = {1'b0, left} + {1'b0, rend} - (CW + 1)'(1);
  assign mid_calc    = AW'(mid_sum >> 1);

  // Compare of the probed entry
  assign hit       = (mem_rdata.unicode == key);
  assign key_below = (key < mem_rdata.unicode);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (lookup_req) state_next = ST_PROBE;
      end
      ST_PROBE: begin
        state_next = window_open ? ST_COMPARE : ST_IDLE;
      end
      ST_COMPARE: begin
        state_next = hit ? ST_IDLE : ST_PROBE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy       = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    emit       = 1'b0;
    emit_found = 1'b0;
    emit_code  = MISS_CODE;
    case (state)
      ST_IDLE: begin
        busy   = 1'b0;
        mem_we = write_req;
      end
      ST_PROBE: begin
        mem_re = window_open;
        emit   = !window_open;
      end
      ST_COMPARE: begin
        if (hit) begin
          emit       = 1'b1;
          emit_found = 1'b1;
          emit_code  = mem_rdata.gbk;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Memory addressing
  assign mem_waddr         = AW'({1'b0, entry_index});
  assign mem_wdata.unicode = entry_unicode;
  assign mem_wdata.gbk     = entry_gbk;
  assign mem_raddr         = mid_calc;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search window
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (lookup_req) begin
          key  <= search_key;
          left <= '0;
          rend <= n_sat;
        end
      end
      ST_PROBE: begin
        mid <= mid_calc;
      end
      ST_COMPARE: begin
        if (!hit) begin
          if (key_below) begin
            rend <= CW'(mid);
          end else begin
            left <= CW'(mid) + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      gbk_code <= emit_code;
      found    <= emit_found;
    end
  end

endmodule

/* rtl/unicode_to_gbk_lookup.sv */
// Top level of the Unicode to GBK lookup block.
//
// Usage:
//   Request channel: start with mode, entry_index, entry_unicode, entry_gbk and
//   search_key. A request is taken at a clock edge with start high and busy low.
//   mode = 0 writes one table entry in that cycle and gives no result; an index
//   at or above TABLE_DEPTH is dropped. mode = 1 looks up search_key.
//   Config: entries_used is written through cfg_we / cfg_data; the user must
//   write it only while idle, since the block does not enforce this.
//   Result channel: result_valid pulses for one cycle with gbk_code and found.
//   A lookup binary-searches the first entries_used entries, capped at
//   TABLE_DEPTH; each probe is a table read in ST_PROBE followed by a compare
//   of the read entry in ST_COMPARE. busy stays high during the search; the
//   next request is taken in the cycle the result is shown. Reset clears the
//   sequencer and entries_used; table contents are undefined until written.
//   The receiver cannot stall; results are never held.
`timescale 1ns / 1ps

module unicode_to_gbk_lookup import ugl_pkg::*; #(
  parameter int TABLE_DEPTH = 32768
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              mode,
  input  logic [14:0]       entry_index,
  input  logic [CODE_W-1:0] entry_unicode,
  input  logic [CODE_W-1:0] entry_gbk,
  input  logic [CODE_W-1:0] search_key,
  input  logic              cfg_we,
  input  logic [CODE_W-1:0] cfg_data,
  output logic              result_valid,
  output logic [CODE_W-1:0] gbk_code,
  output logic              found
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CODE_W-1:0] entries_used;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_used <= '0;
    end else if (cfg_we) begin
      entries_used <= cfg_data;
    end
  end

  ugl_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_search (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .mode          (mode),
    .entry_index   (entry_index),
    .entry_unicode (entry_unicode),
    .entry_gbk     (entry_gbk),
    .search_key    (search_key),
    .entries_used  (entries_used),
    .busy          (busy),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .result_valid  (result_valid),
    .gbk_code      (gbk_code),
    .found         (found)
  );

  ugl_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* rtl/ugl_checker.sv */
// Port-level assertions for the lookup block and their bind.
`timescale 1ns / 1ps

module ugl_checker import ugl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              mode,
  input logic              result_valid,
  input logic [CODE_W-1:0] gbk_code,
  input logic              found
);

  // Reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("block not idle after reset");

  // A taken lookup keeps the block busy for at least the next cycle
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_LOOKUP)) |=> busy)
    else $error("lookup request did not raise busy");

  // A result is shown only once the search has finished
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  // Results never come in two adjacent cycles
  a_result_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  // A miss carries a zero code
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (gbk_code == MISS_CODE))
    else $error("miss with nonzero code");

endmodule

bind unicode_to_gbk_lookup ugl_checker u_ugl_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .mode         (mode),
  .result_valid (result_valid),
  .gbk_code     (gbk_code),
  .found        (found)
);
